// ===== hw/rtl/rbsp_pkg.sv =====
// Shared types and constants for the bulk string parser.
`default_nettype none

package rbsp_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned LenW    = 32;
   localparam int unsigned AccW    = 33;
   localparam int unsigned HdrW    = 21;
   localparam int unsigned DigW    = 5;
   localparam int unsigned IdxW    = 2;

   localparam logic [AccW-1:0] AccMax  = {AccW{1'b1}};
   localparam logic [HdrW-1:0] HdrMax  = {HdrW{1'b1}};
   localparam logic [DigW-1:0] DigMax  = {DigW{1'b1}};

   localparam logic [ByteW-1:0] ChrCr    = 8'h0d;
   localparam logic [ByteW-1:0] ChrLf    = 8'h0a;
   localparam logic [ByteW-1:0] ChrMinus = 8'h2d;
   localparam logic [ByteW-1:0] ChrZero  = 8'h30;
   localparam logic [ByteW-1:0] ChrNine  = 8'h39;

   localparam logic [ByteW-1:0] MagicReset  = 8'd36;
   localparam logic [LenW-1:0]  MaxLenReset = 32'd536870912;
   localparam logic [HdrW-1:0]  HdrLimReset = 21'd65536;

   typedef enum logic [IdxW-1:0] {
      CSR_MAGIC   = 2'd0,
      CSR_MAX_LEN = 2'd1,
      CSR_HDR_LIM = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_NULL  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_MAGIC    = 2'd0,
      ERR_HDR_LONG = 2'd1,
      ERR_NO_LEN   = 2'd2,
      ERR_BAD_LEN  = 2'd3
   } err_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_TRAIL1 = 5'b01000,
      PH_TRAIL2 = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] magic_byte;
      logic [LenW-1:0]  max_length;
      logic [HdrW-1:0]  header_limit;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [ByteW-1:0] payload_byte;
      logic [LenW-1:0]  string_length;
      err_type          error_code;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rbsp_fsm.sv =====
// Frame state machine: header decode, length check, data and trailer tracking.
`default_nettype none

module rbsp_fsm
   import rbsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [ByteW-1:0] data_byte,
   input  wire cfg_type          cfg,
   output result_type            result,
   output logic                  idle
);

   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [DigW-1:0]  dig_cnt_ff, dig_cnt_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic [HdrW-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [LenW-1:0]  left_ff, left_in;
   logic             cr_ff, cr_in;

   logic [HdrW-1:0]  hdr_inc;
   logic [AccW+3:0]  acc_sum;
   logic [AccW-1:0]  acc_digit;
   logic [AccW-1:0]  len_sel;
   logic             is_digit;
   logic             clear;
   logic [LenW-1:0]  left_dec;

   assign idle     = (phase_ff == PH_IDLE);
   assign hdr_inc  = (hdr_cnt_ff == HdrMax) ? hdr_cnt_ff : hdr_cnt_ff + 1'b1;
   assign is_digit = (data_byte >= ChrZero) && (data_byte <= ChrNine);
   assign acc_sum  = (AccW+4)'({acc_ff, 3'b000}) + (AccW+4)'({acc_ff, 1'b0})
                   + (AccW+4)'(data_byte[3:0]);
   assign acc_digit = (acc_sum[AccW+3:AccW] != '0) ? AccMax : acc_sum[AccW-1:0];
   assign left_dec  = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      dig_cnt_in = dig_cnt_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      hdr_cnt_in = hdr_cnt_ff;
      left_in    = left_ff;
      cr_in      = cr_ff;
      clear      = 1'b0;
      len_sel    = '0;
      result     = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (data_byte != cfg.magic_byte) begin
               clear             = 1'b1;
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_MAGIC;
            end else if (cfg.header_limit == '0) begin
               clear             = 1'b1;
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_HDR_LONG;
            end else begin
               phase_in   = PH_HEADER;
               neg_in     = 1'b0;
               dig_cnt_in = '0;
               acc_in     = '0;
               bad_in     = 1'b0;
               hdr_cnt_in = HdrW'(1);
               left_in    = '0;
               cr_in      = 1'b0;
            end
         end
         PH_HEADER: begin
            hdr_cnt_in = hdr_inc;
            if (cr_ff && (data_byte == ChrLf)) begin
               len_sel = acc_ff;
               if (hdr_cnt_ff == HdrW'(2)) begin
                  clear             = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_NO_LEN;
               end else if (bad_ff || (dig_cnt_ff == '0)
                            || (neg_ff && (acc_ff > AccW'(1)))
                            || (!neg_ff && (acc_ff > AccW'(cfg.max_length)))) begin
                  clear             = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_BAD_LEN;
               end else if (neg_ff && (acc_ff == AccW'(1))) begin
                  clear        = 1'b1;
                  result.valid = 1'b1;
                  result.kind  = KIND_NULL;
               end else begin
                  acc_in   = len_sel;
                  left_in  = len_sel[LenW-1:0];
                  cr_in    = 1'b0;
                  phase_in = (len_sel == '0) ? PH_TRAIL1 : PH_DATA;
               end
            end else begin
               bad_in = bad_ff | cr_ff;
               if (data_byte == ChrCr) begin
                  cr_in = 1'b1;
               end else begin
                  cr_in = 1'b0;
                  if ((data_byte == ChrMinus) && (hdr_cnt_ff == HdrW'(1))) begin
                     neg_in = 1'b1;
                  end else if (is_digit) begin
                     acc_in     = acc_digit;
                     dig_cnt_in = (dig_cnt_ff == DigMax) ? dig_cnt_ff : dig_cnt_ff + 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               if (hdr_inc > cfg.header_limit) begin
                  clear             = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_HDR_LONG;
               end
            end
         end
         PH_DATA: begin
            left_in             = left_dec;
            phase_in            = (left_dec == '0) ? PH_TRAIL1 : PH_DATA;
            result.valid        = 1'b1;
            result.kind         = KIND_DATA;
            result.payload_byte = data_byte;
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            clear                = 1'b1;
            result.valid         = 1'b1;
            result.kind          = KIND_END;
            result.string_length = acc_ff[LenW-1:0];
         end
         default: begin
            clear = 1'b1;
         end
      endcase

      if (clear) begin
         phase_in   = PH_IDLE;
         hdr_cnt_in = '0;
         neg_in     = 1'b0;
         dig_cnt_in = '0;
         acc_in     = '0;
         bad_in     = 1'b0;
         left_in    = '0;
         cr_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         neg_ff     <= 1'b0;
         dig_cnt_ff <= '0;
         acc_ff     <= '0;
         bad_ff     <= 1'b0;
         hdr_cnt_ff <= '0;
         left_ff    <= '0;
         cr_ff      <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         dig_cnt_ff <= dig_cnt_in;
         acc_ff     <= acc_in;
         bad_ff     <= bad_in;
         hdr_cnt_ff <= hdr_cnt_in;
         left_ff    <= left_in;
         cr_ff      <= cr_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rbsp_out_reg.sv =====
// Result register that holds one beat until the downstream side takes it.
`default_nettype none

module rbsp_out_reg
   import rbsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type res_in,
   input  wire logic       out_stall,
   output logic            free,
   output logic            out_valid,
   output result_type      out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free      = !valid_ff || !out_stall;
   assign valid_in  = res_in.valid || (valid_ff && out_stall);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_in.valid) begin
         data_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/resp_bulk_string_parser_core.sv =====
// Top level of the bulk string parser: input register, configuration and result stage.
`default_nettype none

// The parser takes one stream byte per clock while req_stall is low and gives at most one
// result beat per byte. A byte is held in the input register while the frame state machine
// decodes it, and its result is loaded into the result register when the byte advances; the
// result register presents the beat until the downstream side takes it.
// Sustained rate is one byte per cycle; the only limit is the result register, and
// req_stall rises only while a byte waits behind a stalled result beat.
// Configuration writes are registered and are meant for an idle parser.
module resp_bulk_string_parser_core
   import rbsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [IdxW-1:0]  csr_index,
   input  wire logic [LenW-1:0]  csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ByteW-1:0] req_data_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [ByteW-1:0]      rsp_payload_byte,
   output logic [LenW-1:0]       rsp_string_length,
   output logic [1:0]            rsp_error_code
);

   cfg_type          cfg_ff;
   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             advance;
   logic             out_free;
   logic             fsm_idle;
   result_type       step_res, load_res, out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_byte   <= MagicReset;
         cfg_ff.max_length   <= MaxLenReset;
         cfg_ff.header_limit <= HdrLimReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:   cfg_ff.magic_byte   <= csr_wdata[ByteW-1:0];
            CSR_MAX_LEN: cfg_ff.max_length   <= csr_wdata;
            CSR_HDR_LIM: cfg_ff.header_limit <= csr_wdata[HdrW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   rbsp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .result    (step_res),
      .idle      (fsm_idle)
   );

   always_comb begin
      load_res       = step_res;
      load_res.valid = step_res.valid && advance;
   end

   rbsp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .res_in    (load_res),
      .out_stall (rsp_stall),
      .free      (out_free),
      .out_valid (rsp_valid),
      .out_data  (out_res)
   );

   assign rsp_kind          = out_res.kind;
   assign rsp_payload_byte  = out_res.payload_byte;
   assign rsp_string_length = out_res.string_length;
   assign rsp_error_code    = out_res.error_code;

   a_stall_only_behind_result: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall)
   ) else $error("input stalled without a blocked result beat");

   a_frame_close_to_idle: assert property (
      @(posedge clock) disable iff (reset)
      (load_res.valid && (load_res.kind != KIND_DATA)) |=> fsm_idle
   ) else $error("parser not idle after closing a frame");

   a_result_loaded: assert property (
      @(posedge clock) disable iff (reset)
      load_res.valid |=> (rsp_valid && (rsp_kind == $past(load_res.kind)))
   ) else $error("result beat lost in the result register");

endmodule

`default_nettype wire
